FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ircp_pkg.sv
// Types and constants of the infrared capture parser
package ircp_pkg;

  localparam int DIV_W = 32;
  localparam int DSR_W = 16;

  typedef enum logic [2:0] {
    KIND_INTERSPACE = 3'd0,
    KIND_PULSE      = 3'd1,
    KIND_SPACE      = 3'd2,
    KIND_END_TERM   = 3'd3,
    KIND_END_LONG   = 3'd4
  } rec_kind_t;

  typedef enum logic [1:0] {
    PH_INTERSPACE = 2'd0,
    PH_PULSE      = 2'd1,
    PH_SPACE      = 2'd2,
    PH_UNUSED     = 2'd3
  } phase_t;

  localparam logic [7:0]  TERM_BYTE      = 8'hff;
  localparam logic [15:0] LONG_SPACE_MAX = 16'h3e80;
  localparam logic [31:0] CARRIER_NUM    = 32'd250000;
  localparam logic [24:0] ISP_SCALE      = 25'd500;
  localparam logic [10:0] SAMPLE_MAX     = 11'd2047;

endpackage

FILE: hw/rtl/ircp_in_if.sv
// Input byte channel of the parser
interface ircp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/ircp_out_if.sv
// Result record channel of the parser
interface ircp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rec_kind;
  logic [15:0] duration;
  logic [14:0] carriers;
  logic [31:0] freq_estimate;
  logic [10:0] pulse_total;

  modport source (output valid, output rec_kind, output duration, output carriers,
                  output freq_estimate, output pulse_total, input ready);
  modport sink   (input valid, input rec_kind, input duration, input carriers,
                  input freq_estimate, input pulse_total, output ready);
endinterface

FILE: hw/rtl/ircp_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module ircp_divider
  import ircp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DIV_W-1:0] q_r;

  logic [DSR_W:0]   shifted;
  logic [DSR_W+1:0] diff;
  logic             ge;
  logic [DSR_W-1:0] rem_nxt;
  logic [DIV_W-1:0] q_nxt;

  always_comb begin
    shifted = {rem_r, q_r[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    ge      = !diff[DSR_W+1];
    rem_nxt = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
    q_nxt   = {q_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

  `ASSERT_CLK(a_div_no_restart, start |-> !busy_r, "divider started while busy")

endmodule

FILE: hw/rtl/ir_raw_capture_parser.sv
// Top level of the byte-serial infrared capture parser
// Usage:
//   in_ch  : one capture byte per request (valid/ready). The first two bytes are the
//            interspace, then pulse and space records alternate.
//   out_ch : one record per completed interspace, pulse, space or capture end.
//            End records carry the averaged carrier estimate and the pulse total.
// Byte handling:
//   A byte that completes nothing, or a pulse without a frequency sample, is
//   taken in the idle state. A pulse with a sample occupies the shared 32-step
//   divider and the multiply/accumulate; no further byte is taken until both
//   are done. An end record with samples waits for the divider result.
// Reset: rst_n (synchronous, active low) returns the parser to the interspace
//   phase with all totals cleared; an end record does the same.
// Stalls: one output register holds a finished record; while it is full and
//   out_ch.ready is low, in_ch.ready stays low.
`include "assert_macros.svh"

module ir_raw_capture_parser
  import ircp_pkg::*;
#(
  parameter int MAX_PULSES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  ircp_in_if.sink         in_ch,
  ircp_out_if.source      out_ch
);

  localparam int PCW = $clog2(MAX_PULSES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_QDIV,
    S_ACC,
    S_AVG
  } state_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [15:0]      asm_r, asm_nxt;
  logic [6:0]       chold_r, chold_nxt;
  logic [31:0]      fsum_r, fsum_nxt;
  logic [10:0]      scnt_r, scnt_nxt;
  logic [PCW-1:0]   pcnt_r, pcnt_nxt;
  logic [18:0]      mfac_r, mfac_nxt;
  logic [31:0]      prod_r, prod_nxt;

  logic             out_valid_r, out_valid_nxt;
  rec_kind_t        out_kind_r, out_kind_nxt;
  logic [15:0]      out_dur_r, out_dur_nxt;
  logic [14:0]      out_car_r, out_car_nxt;
  logic [31:0]      out_freq_r, out_freq_nxt;
  logic [10:0]      out_tot_r, out_tot_nxt;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  logic             acc;
  logic [7:0]       b;
  logic             end_p;
  logic [14:0]      c_sel;
  logic             fin;
  rec_kind_t        fin_kind;
  logic [15:0]      fin_dur;
  logic [15:0]      word;
  logic [24:0]      isp_full;
  logic [36:0]      mul_full;
  logic [31:0]      pcnt_ext;

  ircp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign word        = {asm_r[15:8], b};
  assign isp_full    = {9'b0, word} * ISP_SCALE;
  assign mul_full    = {19'b0, div_quot[17:0]} * {18'b0, mfac_r};
  assign pcnt_ext    = 32'(pcnt_r);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    asm_nxt       = asm_r;
    chold_nxt     = chold_r;
    fsum_nxt      = fsum_r;
    scnt_nxt      = scnt_r;
    pcnt_nxt      = pcnt_r;
    mfac_nxt      = mfac_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_dur_nxt   = out_dur_r;
    out_car_nxt   = out_car_r;
    out_freq_nxt  = out_freq_r;
    out_tot_nxt   = out_tot_r;
    div_start     = 1'b0;
    div_dividend  = CARRIER_NUM;
    div_divisor   = asm_r;
    end_p         = 1'b0;
    c_sel         = '0;
    fin           = 1'b0;
    fin_kind      = KIND_END_TERM;
    fin_dur       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (phase_r)
            PH_PULSE: begin
              unique case (pos_r)
                2'd0: begin
                  asm_nxt = {b, 8'h00};
                  pos_nxt = 2'd1;
                end
                2'd1: begin
                  asm_nxt = word;
                  pos_nxt = 2'd2;
                end
                2'd2: begin
                  if (b[7]) begin
                    chold_nxt = b[6:0];
                    pos_nxt   = 2'd3;
                  end else begin
                    end_p = 1'b1;
                    c_sel = {7'b0, b};
                  end
                end
                default: begin
                  end_p = 1'b1;
                  c_sel = {chold_r, b};
                end
              endcase
            end
            PH_SPACE: begin
              if (pos_r == 2'd0) begin
                if (b == TERM_BYTE) begin
                  fin      = 1'b1;
                  fin_kind = KIND_END_TERM;
                  fin_dur  = '0;
                end else begin
                  asm_nxt = {b, 8'h00};
                  pos_nxt = 2'd1;
                end
              end else begin
                pos_nxt = 2'd0;
                asm_nxt = '0;
                if (word > LONG_SPACE_MAX) begin
                  fin      = 1'b1;
                  fin_kind = KIND_END_LONG;
                  fin_dur  = word;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = KIND_SPACE;
                  out_dur_nxt   = word;
                  out_car_nxt   = '0;
                  out_freq_nxt  = '0;
                  out_tot_nxt   = '0;
                  phase_nxt     = PH_PULSE;
                end
              end
            end
            default: begin
              if (pos_r == 2'd0) begin
                phase_nxt = PH_INTERSPACE;
                asm_nxt   = {b, 8'h00};
                pos_nxt   = 2'd1;
              end else begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_INTERSPACE;
                out_dur_nxt   = isp_full[24:9];
                out_car_nxt   = '0;
                out_freq_nxt  = '0;
                out_tot_nxt   = '0;
                phase_nxt     = PH_PULSE;
                pos_nxt       = 2'd0;
                asm_nxt       = '0;
              end
            end
          endcase

          if (end_p) begin
            if (c_sel != '0 && asm_r != '0 && scnt_r != SAMPLE_MAX) begin
              scnt_nxt  = scnt_r + 1'b1;
              mfac_nxt  = ({c_sel, 3'b000} + {2'b00, c_sel, 1'b0}) - 19'd5;
              div_start = 1'b1;
              state_nxt = S_QDIV;
            end
            if (pcnt_r != PCW'(MAX_PULSES)) begin
              pcnt_nxt = pcnt_r + 1'b1;
            end
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_PULSE;
            out_dur_nxt   = asm_r;
            out_car_nxt   = c_sel;
            out_freq_nxt  = '0;
            out_tot_nxt   = '0;
            phase_nxt     = PH_SPACE;
            pos_nxt       = 2'd0;
            chold_nxt     = '0;
          end

          if (fin) begin
            out_kind_nxt = fin_kind;
            out_dur_nxt  = fin_dur;
            out_car_nxt  = '0;
            out_freq_nxt = 32'd1;
            out_tot_nxt  = pcnt_ext[10:0];
            if (scnt_r != '0) begin
              div_start    = 1'b1;
              div_dividend = fsum_r;
              div_divisor  = {5'b0, scnt_r};
              state_nxt    = S_AVG;
            end else begin
              out_valid_nxt = 1'b1;
            end
            phase_nxt = PH_INTERSPACE;
            pos_nxt   = '0;
            asm_nxt   = '0;
            chold_nxt = '0;
            fsum_nxt  = '0;
            scnt_nxt  = '0;
            pcnt_nxt  = '0;
          end
        end
      end
      S_QDIV: begin
        if (div_done) begin
          prod_nxt  = mul_full[31:0];
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        fsum_nxt  = fsum_r + prod_r;
        state_nxt = S_IDLE;
      end
      S_AVG: begin
        if (div_done) begin
          out_freq_nxt  = div_quot;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_INTERSPACE;
      pos_r       <= '0;
      asm_r       <= '0;
      chold_r     <= '0;
      fsum_r      <= '0;
      scnt_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      asm_r       <= asm_nxt;
      chold_r     <= chold_nxt;
      fsum_r      <= fsum_nxt;
      scnt_r      <= scnt_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mfac_r     <= mfac_nxt;
    prod_r     <= prod_nxt;
    out_kind_r <= out_kind_nxt;
    out_dur_r  <= out_dur_nxt;
    out_car_r  <= out_car_nxt;
    out_freq_r <= out_freq_nxt;
    out_tot_r  <= out_tot_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rec_kind      = out_kind_r;
  assign out_ch.duration      = out_dur_r;
  assign out_ch.carriers      = out_car_r;
  assign out_ch.freq_estimate = out_freq_r;
  assign out_ch.pulse_total   = out_tot_r;

  `ASSERT_CLK(a_div_busy_not_idle, div_busy |-> state_r != S_IDLE, "divider busy while idle")
  `ASSERT_CLK(a_div_done_waited, div_done |-> (state_r == S_QDIV || state_r == S_AVG), "stray divider done")
  `ASSERT_CLK(a_avg_loads_out, (state_r == S_AVG && div_done) |=> out_valid_r, "end record not loaded")
  `ASSERT_CLK(a_pulse_sat, pcnt_r <= PCW'(MAX_PULSES), "pulse count beyond limit")

endmodule

FILE: tb/sv/ircp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the capture parser: predicts records from accepted bytes and compares them
module ircp_checker
  import ircp_pkg::*;
#(
  parameter int MAX_PULSES = 1024
) (
  input  logic clk,
  input  logic rst_n,
  ircp_in_if   in_ch,
  ircp_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   records_checked,
  output int   captures_closed
);

  typedef struct packed {
    rec_kind_t   kind;
    logic [15:0] dur;
    logic [14:0] car;
    logic [31:0] freq;
    logic [10:0] tot;
  } capture_rec_t;

  capture_rec_t expected_recs[$];

  phase_t      ph;
  logic [1:0]  pos;
  logic [15:0] acc;
  logic [6:0]  car_hi;
  logic [31:0] freq_sum;
  logic [10:0] n_samples;
  logic [10:0] n_pulses;

  int fails;
  int checked;
  int closed;

  function automatic void clear_parse();
    ph        = PH_INTERSPACE;
    pos       = '0;
    acc       = '0;
    car_hi    = '0;
    freq_sum  = '0;
    n_samples = '0;
    n_pulses  = '0;
  endfunction

  function automatic capture_rec_t end_capture(rec_kind_t kind, logic [15:0] dur);
    capture_rec_t r;
    r      = '0;
    r.kind = kind;
    r.dur  = dur;
    r.freq = (n_samples != 0) ? freq_sum / {21'd0, n_samples} : 32'd1;
    r.tot  = n_pulses;
    clear_parse();
    return r;
  endfunction

  function automatic capture_rec_t log_pulse(logic [14:0] c);
    capture_rec_t r;
    r = '0;
    if (c != 0 && acc != 0 && n_samples < SAMPLE_MAX) begin
      freq_sum  = freq_sum + (CARRIER_NUM / {16'd0, acc}) * (32'd10 * {17'd0, c} - 32'd5);
      n_samples = n_samples + 11'd1;
    end
    if (n_pulses < MAX_PULSES) n_pulses = n_pulses + 11'd1;
    r.kind = KIND_PULSE;
    r.dur  = acc;
    r.car  = c;
    ph     = PH_SPACE;
    pos    = '0;
    car_hi = '0;
    return r;
  endfunction

  // returns 1 when the byte completes a record
  function automatic bit parse_byte(input logic [7:0] b, output capture_rec_t rec);
    logic [31:0] scaled;
    logic [15:0] gap;
    rec = '0;
    case (ph)
      PH_PULSE: begin
        case (pos)
          2'd0: begin
            acc = {b, 8'h00};
            pos = 2'd1;
          end
          2'd1: begin
            acc = acc | {8'h00, b};
            pos = 2'd2;
          end
          2'd2: begin
            if (b[7]) begin
              car_hi = b[6:0];
              pos    = 2'd3;
            end else begin
              rec = log_pulse({7'd0, b});
              return 1'b1;
            end
          end
          default: begin
            rec = log_pulse({car_hi, b});
            return 1'b1;
          end
        endcase
        return 1'b0;
      end
      PH_SPACE: begin
        if (pos == 2'd0) begin
          if (b == TERM_BYTE) begin
            rec = end_capture(KIND_END_TERM, 16'd0);
            return 1'b1;
          end
          acc = {b, 8'h00};
          pos = 2'd1;
          return 1'b0;
        end
        gap = {acc[15:8], b};
        pos = '0;
        acc = '0;
        if (gap > LONG_SPACE_MAX) begin
          rec = end_capture(KIND_END_LONG, gap);
        end else begin
          rec.kind = KIND_SPACE;
          rec.dur  = gap;
          ph       = PH_PULSE;
        end
        return 1'b1;
      end
      default: begin
        // phase code 3 falls in here as interspace
        if (pos == 2'd0) begin
          ph  = PH_INTERSPACE;
          acc = {b, 8'h00};
          pos = 2'd1;
          return 1'b0;
        end
        scaled   = ({16'd0, acc[15:8], b} * 32'd500) / 32'd512;
        rec.kind = KIND_INTERSPACE;
        rec.dur  = scaled[15:0];
        ph       = PH_PULSE;
        pos      = '0;
        acc      = '0;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int diff_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  initial clear_parse();

  always @(posedge clk) begin : watch
    capture_rec_t want;
    capture_rec_t got;
    if (!rst_n) begin
      clear_parse();
      expected_recs.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = rec_kind_t'(out_ch.rec_kind);
        got.dur  = out_ch.duration;
        got.car  = out_ch.carriers;
        got.freq = out_ch.freq_estimate;
        got.tot  = out_ch.pulse_total;
        if (expected_recs.size() == 0) begin
          $error("record of kind %0d with no request pending", out_ch.rec_kind);
          fails++;
        end else begin
          want  = expected_recs.pop_front();
          fails += diff_field("rec_kind", want.kind, got.kind)
                 + diff_field("duration", want.dur, got.dur)
                 + diff_field("carriers", want.car, got.car)
                 + diff_field("freq_estimate", want.freq, got.freq)
                 + diff_field("pulse_total", want.tot, got.tot);
          checked++;
          if (want.kind == KIND_END_TERM || want.kind == KIND_END_LONG) closed++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.in_byte, want)) expected_recs.push_back(want);
      end
    end
    fail_count      <= fails;
    pending         <= expected_recs.size();
    records_checked <= checked;
    captures_closed <= closed;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the capture parser: byte stimulus, result drain and verdict
module tb_top;
  import ircp_pkg::*;

  logic clk;
  logic rst_n;

  ircp_in_if  in_ch();
  ircp_out_if out_ch();

  int fail_count;
  int pending_recs;
  int recs_checked;
  int ends_checked;
  int bytes_sent;
  bit steady_feed;

  // framing tracker, so noise can be followed by a clean capture
  phase_t     g_phase;
  logic [1:0] g_pos;
  logic [7:0] g_hi;

  // zero-length interspace/pulse, 0xff as plain data, zero carrier count (one and two
  // bytes), widest carrier, space at the limit and one past it, end without samples
  localparam logic [7:0] OPENING [25] = '{
    8'hff, 8'hff,
    8'h00, 8'h00, 8'h05,
    8'h3e, 8'h80,
    8'hff, 8'hff, 8'h00,
    8'h00, 8'hff,
    8'h00, 8'h01, 8'hff, 8'hff,
    8'hff,
    8'h00, 8'h00,
    8'h12, 8'h34, 8'h80, 8'h00,
    8'h3e, 8'h81
  };

  ir_raw_capture_parser #(.MAX_PULSES(1024)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ircp_checker #(.MAX_PULSES(1024)) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending         (pending_recs),
    .records_checked (recs_checked),
    .captures_closed (ends_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady_feed && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    case (g_phase)
      PH_PULSE: begin
        if ((g_pos == 2'd2 && !b[7]) || g_pos == 2'd3) begin
          g_phase = PH_SPACE;
          g_pos   = '0;
        end else begin
          g_pos = g_pos + 2'd1;
        end
      end
      PH_SPACE: begin
        if (g_pos == 2'd0 && b == TERM_BYTE) begin
          g_phase = PH_INTERSPACE;
        end else if (g_pos == 2'd0) begin
          g_hi  = b;
          g_pos = 2'd1;
        end else begin
          if ({g_hi, b} > LONG_SPACE_MAX) g_phase = PH_INTERSPACE;
          else g_phase = PH_PULSE;
          g_pos = '0;
        end
      end
      default: begin
        if (g_pos == 2'd0) begin
          g_pos = 2'd1;
        end else begin
          g_phase = PH_PULSE;
          g_pos   = '0;
        end
      end
    endcase
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // tame: nonzero durations and one-byte counts, so every pulse yields a sample
  task automatic send_capture(input int pairs, input bit tame);
    logic [15:0] dur;
    logic [14:0] car;
    int r;
    send_word(16'($urandom_range(0, 65535)));
    for (int k = 0; k < pairs; k++) begin
      r = $urandom_range(99);
      if (tame) dur = 16'($urandom_range(1, 2000));
      else if (r < 10) dur = 16'd0;
      else if (r < 40) dur = 16'($urandom_range(1, 255));
      else dur = 16'($urandom_range(0, 65535));
      r = $urandom_range(99);
      if (tame) car = 15'($urandom_range(1, 127));
      else if (r < 10) car = 15'd0;
      else if (r < 50) car = 15'($urandom_range(1, 127));
      else car = 15'($urandom_range(0, 32767));
      send_word(dur);
      if (car > 15'd127 || (!tame && $urandom_range(3) == 0)) begin
        send_byte({1'b1, car[14:8]});
        send_byte(car[7:0]);
      end else begin
        send_byte(car[7:0]);
      end
      if (k < pairs - 1) send_word(16'($urandom_range(0, 16'h3e80)));
    end
    if (tame || $urandom_range(1) == 0) send_byte(TERM_BYTE);
    else send_word(16'($urandom_range(16'h3e81, 16'hfeff)));
  endtask

  task automatic random_burst();
    int n;
    if ($urandom_range(99) < 75) begin
      send_capture($urandom_range(1, 12), 1'b0);
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      while (!(g_phase == PH_INTERSPACE && g_pos == 2'd0))
        send_byte((g_phase == PH_SPACE && g_pos == 2'd0) ? TERM_BYTE :
                  8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int target;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    steady_feed   = 1'b0;
    g_phase       = PH_INTERSPACE;
    g_pos         = '0;
    g_hi          = '0;
    bytes_sent    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_byte(OPENING[i]);
    while (bytes_sent < 350) begin
      steady_feed = (bytes_sent < 175);
      random_burst();
    end
    steady_feed = 1'b0;
    // one long capture in which every pulse adds a frequency sample
    send_capture(50, 1'b1);
    target = bytes_sent + 200;
    while (bytes_sent < target) random_burst();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_recs != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d capture bytes; checked %0d records, %0d of them capture ends,",
             bytes_sent, recs_checked, ends_checked);
    $display("including noise bursts, a long output stall and a long all-sample capture.");
    if (fail_count == 0 && pending_recs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : drain
    int cyc;
    int hold;
    cyc = 0;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 2500) hold = 600;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (cyc >= 500 && cyc < 2000) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin : watchdog
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: ir_raw_capture_parser.f
+incdir+hw/rtl
hw/rtl/ircp_pkg.sv
hw/rtl/ircp_in_if.sv
hw/rtl/ircp_out_if.sv
hw/rtl/ircp_divider.sv
hw/rtl/ir_raw_capture_parser.sv
tb/sv/ircp_checker.sv
tb/sv/tb_top.sv
